/* sv/mdq_pkg.sv */
// ----------------------------------------------------------------------------
// mdq_pkg: shared types and constants of the deque bank
// command and result codes, field widths, default sizes, controller states
// ----------------------------------------------------------------------------
package mdq_pkg;

  localparam int NUM_QUEUES_DEF = 16;
  localparam int DEPTH_DEF      = 256;

  localparam int CMD_W  = 3;
  localparam int QIDX_W = 4;
  localparam int WORD_W = 32;
  localparam int KIND_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_POP_BACK   = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_SIZE       = 3'd4,
    CMD_FRONT      = 3'd5,
    CMD_BACK       = 3'd6
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SIZE  = 2'd0,
    KIND_FRONT = 2'd1,
    KIND_BACK  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_META,
    ST_DATA
  } state_t;

endpackage

/* sv/mdq_if.sv */
// ----------------------------------------------------------------------------
// mdq_if: command and response channels of the deque bank
// valid/ready channels, a word moves when valid and ready are both high
// ----------------------------------------------------------------------------
interface mdq_cmd_if import mdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [QIDX_W-1:0]        queue_index;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output command, output queue_index, output value,
                  input ready);
  modport sink   (input valid, input command, input queue_index, input value,
                  output ready);
endinterface

interface mdq_rsp_if import mdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        result_kind;
  logic signed [WORD_W-1:0] result_value;

  modport source (output valid, output result_kind, output result_value,
                  input ready);
  modport sink   (input valid, input result_kind, input result_value,
                  output ready);
endinterface

/* sv/mdq_ram.sv */
// ----------------------------------------------------------------------------
// mdq_ram: generic simple dual-port ram
// one write port, one read port with registered data held while re is low
// ----------------------------------------------------------------------------
module mdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/multi_deque_bank.sv */
// ----------------------------------------------------------------------------
// multi_deque_bank: bank of double-ended queues of signed 32-bit words
// every queue is a ring in one entry ram, head and count per queue in a
// second ram; a small controller reads, modifies and writes back
// ----------------------------------------------------------------------------
// result path: a size answer is loaded into the output register from the
//   META state, a front/back word from the DATA state after the entry ram read
// command flow: a new command word is taken only in IDLE, after the
//   head/count ram read and its write-back and, for front/back, the entry
//   ram read; a full output register holds a size, front or back command
// reset: synchronous; a clearing pass zeroes every head and count, one
//   queue at a time, before the first command word is taken
// ----------------------------------------------------------------------------
module multi_deque_bank import mdq_pkg::*; #(
  parameter int NUM_QUEUES = NUM_QUEUES_DEF,
  parameter int DEPTH      = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mdq_cmd_if.sink   req,
  mdq_rsp_if.source rsp
);

  // widths that follow from the bank size
  localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int ED  = NUM_QUEUES * DEPTH;
  localparam int EAW = $clog2(ED);
  localparam int MW  = PW + CW;

  localparam logic [PW:0]     DEPTH_SUM = (PW + 1)'(DEPTH);
  localparam logic [PW-1:0]   LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0]   FULL_CNT  = CW'(DEPTH);
  localparam logic [QW-1:0]   LAST_Q    = QW'(NUM_QUEUES - 1);
  localparam logic [EAW-1:0]  DEPTH_A   = EAW'(DEPTH);
  localparam logic [QIDX_W:0] NQ_LIMIT  = (NUM_QUEUES > 16) ? 5'd16 : (QIDX_W + 1)'(NUM_QUEUES);

  // per-queue bookkeeping word
  typedef struct packed {
    logic [PW-1:0] head;
    logic [CW-1:0] count;
  } qmeta_t;

  // ring slot of (head + offset), both below DEPTH
  function automatic logic [PW-1:0] slot_add(logic [PW-1:0] h, logic [PW-1:0] o);
    logic [PW:0] sum;
    sum = {1'b0, h} + {1'b0, o};
    if (sum >= DEPTH_SUM) begin
      sum = sum - DEPTH_SUM;
    end
    return sum[PW-1:0];
  endfunction

  // flat entry ram address of a slot in a queue
  function automatic logic [EAW-1:0] entry_addr(logic [QIDX_W-1:0] q, logic [PW-1:0] s);
    return EAW'(q) * DEPTH_A + EAW'(s);
  endfunction

  // controller state
  state_t state, state_next;
  logic [QW-1:0] clr_addr;

  // command word held for the duration of its work
  logic [CMD_W-1:0]         cmd;
  logic [QIDX_W-1:0]        qi;
  logic signed [WORD_W-1:0] value;

  // output register, parts the result side from the command side
  logic                     out_valid;
  logic [KIND_W-1:0]        out_kind;
  logic signed [WORD_W-1:0] out_value;
  logic                     out_load;
  logic [KIND_W-1:0]        load_kind;
  logic [WORD_W-1:0]        load_value;
  logic                     out_free;

  // ram ports
  logic              meta_we;
  logic [QW-1:0]     meta_waddr;
  qmeta_t            meta_wdata;
  logic              meta_re;
  logic [QW-1:0]     meta_raddr;
  logic [MW-1:0]     meta_rdata;
  qmeta_t            meta;

  logic              entry_we;
  logic [EAW-1:0]    entry_waddr;
  logic              entry_re;
  logic [EAW-1:0]    entry_raddr;
  logic [WORD_W-1:0] entry_rdata;

  // decoded view of the bookkeeping word read for this command
  logic          qvalid;
  logic          full;
  logic          empty;
  logic [PW-1:0] head_dec;
  logic [PW-1:0] head_inc;
  logic [PW-1:0] back_slot;
  logic [PW-1:0] tail_slot;

  assign meta      = qmeta_t'(meta_rdata);
  assign qvalid    = ({1'b0, qi} < NQ_LIMIT);
  assign full      = (meta.count == FULL_CNT);
  assign empty     = (meta.count == '0);
  assign head_dec  = (meta.head == '0) ? LAST_SLOT : meta.head - PW'(1);
  assign head_inc  = (meta.head == LAST_SLOT) ? '0 : meta.head + PW'(1);
  // slot after the last word, where a back push writes
  assign tail_slot = slot_add(meta.head, meta.count[PW-1:0]);
  // slot of the last word
  assign back_slot = slot_add(meta.head, PW'(meta.count - CW'(1)));

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE);

  assign rsp.valid        = out_valid;
  assign rsp.result_kind  = out_kind;
  assign rsp.result_value = out_value;

  mdq_ram #(
    .WIDTH (MW),
    .DEPTH (NUM_QUEUES)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  mdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ED)
  ) u_entry_ram (
    .clk   (clk),
    .we    (entry_we),
    .waddr (entry_waddr),
    .wdata (value),
    .re    (entry_re),
    .raddr (entry_raddr),
    .rdata (entry_rdata)
  );

  // state register and clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + QW'(1);
      end
    end
  end

  // command word capture, no reset needed
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd   <= req.command;
      qi    <= req.queue_index;
      value <= req.value;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind  <= load_kind;
      out_value <= load_value;
    end
  end

  // next state, ram controls and output load
  always_comb begin
    state_next  = state;
    meta_we     = 1'b0;
    meta_waddr  = QW'(qi);
    meta_wdata  = meta;
    meta_re     = 1'b0;
    meta_raddr  = QW'(req.queue_index);
    entry_we    = 1'b0;
    entry_waddr = entry_addr(qi, tail_slot);
    entry_re    = 1'b0;
    entry_raddr = entry_addr(qi, meta.head);
    out_load    = 1'b0;
    load_kind   = KIND_SIZE;
    load_value  = WORD_W'(meta.count);

    unique case (state)
      ST_CLEAR: begin
        // zero head and count of one queue per cycle
        meta_we    = 1'b1;
        meta_waddr = clr_addr;
        meta_wdata = '0;
        if (clr_addr == LAST_Q) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req.valid) begin
          meta_re    = 1'b1;
          state_next = ST_META;
        end
      end

      ST_META: begin
        // bookkeeping word of the queue is on the ram output
        state_next = ST_IDLE;
        if (qvalid) begin
          unique case (cmd)
            CMD_PUSH_BACK: begin
              if (!full) begin
                entry_we         = 1'b1;
                meta_we          = 1'b1;
                meta_wdata.count = meta.count + CW'(1);
              end
            end
            CMD_PUSH_FRONT: begin
              if (!full) begin
                entry_we         = 1'b1;
                entry_waddr      = entry_addr(qi, head_dec);
                meta_we          = 1'b1;
                meta_wdata.head  = head_dec;
                meta_wdata.count = meta.count + CW'(1);
              end
            end
            CMD_POP_BACK: begin
              if (!empty) begin
                meta_we          = 1'b1;
                meta_wdata.count = meta.count - CW'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (!empty) begin
                meta_we          = 1'b1;
                meta_wdata.head  = head_inc;
                meta_wdata.count = meta.count - CW'(1);
              end
            end
            CMD_SIZE: begin
              // hold here until the output register frees up
              if (out_free) begin
                out_load = 1'b1;
              end else begin
                state_next = ST_META;
              end
            end
            CMD_FRONT: begin
              if (!empty) begin
                entry_re   = 1'b1;
                state_next = ST_DATA;
              end
            end
            CMD_BACK: begin
              if (!empty) begin
                entry_re    = 1'b1;
                entry_raddr = entry_addr(qi, back_slot);
                state_next  = ST_DATA;
              end
            end
            default: begin
              // unused command code, ignored
            end
          endcase
        end
      end

      ST_DATA: begin
        // end word is on the entry ram output and holds while we wait
        load_kind  = (cmd == CMD_FRONT) ? KIND_FRONT : KIND_BACK;
        load_value = entry_rdata;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // a word waiting in the output register is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || rsp.ready))
    else $error("output word overwritten before taken");

  // a count read back never exceeds the ring depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_META && qvalid) |-> (meta.count <= FULL_CNT))
    else $error("queue count beyond depth");

  // entries are written only by a push into a queue with room
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    entry_we |-> (state == ST_META && !full && qvalid))
    else $error("entry write outside a legal push");

  // a taken command word always moves on to the bookkeeping read
  a_accept_meta: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == ST_META))
    else $error("accepted command did not reach bookkeeping stage");
`endif

endmodule

/* sim/multi_deque_bank_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_deque_bank_tb: self-checking bench for the bank of deques
// drives command words through a table of directed cases and then random
// traffic, predicts answers with its own copy of the rings (typed table rows
// carry their own), and checks each answer word against the oldest prediction
// ----------------------------------------------------------------------------
module multi_deque_bank_tb import mdq_pkg::*; ();

  localparam int NQ           = NUM_QUEUES_DEF;
  localparam int RING_DEPTH   = DEPTH_DEF;
  localparam int HEAD_W       = $clog2(RING_DEPTH);
  localparam int RANDOM_ITEMS = 900;
  localparam int N_DIRECTED   = 24;
  localparam int DRAIN_CYCLES = 20;

  // command code the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  typedef struct packed {
    kind_t                    kind;
    logic signed [WORD_W-1:0] value;
  } deque_answer_t;

  // one command word plus, for table rows, an answer typed in by hand
  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [QIDX_W-1:0]        qi;
    logic signed [WORD_W-1:0] word;
    bit                       typed;
    bit                       answers;
    deque_answer_t            ans;
  } stim_row_t;

  logic clk;
  logic rst;

  mdq_cmd_if req_bus ();
  mdq_rsp_if rsp_bus ();

  multi_deque_bank #(
    .NUM_QUEUES(NQ),
    .DEPTH     (RING_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  // shadow copy of the bank: ring words, head slot and fill level per queue
  logic signed [WORD_W-1:0] ring_words [NQ][RING_DEPTH];
  logic [HEAD_W-1:0]        head_slot  [NQ];
  logic [HEAD_W:0]          word_count [NQ];

  deque_answer_t pending_answers [$];
  int unsigned   words_issued;
  int unsigned   burst_left;
  int unsigned   errors_seen;

  cmd_t read_cmds [3] = '{CMD_SIZE, CMD_FRONT, CMD_BACK};

  // directed cases; rows with typed set carry their answer, the rest are
  // left to the predictor
  stim_row_t directed_rows [N_DIRECTED] = '{
    // bank is empty right after reset
    '{CMD_SIZE,       4'd0,  32'sd0,         1'b1, 1'b1, '{KIND_SIZE,  32'sd0}},
    '{CMD_FRONT,      4'd0,  32'sd0,         1'b1, 1'b0, '{KIND_SIZE,  32'sd0}},
    '{CMD_BACK,       4'd15, -32'sd1,        1'b1, 1'b0, '{KIND_SIZE,  32'sd0}},
    // pops on an empty queue do nothing
    '{CMD_POP_BACK,   4'd3,  32'sd5,         1'b1, 1'b0, '{KIND_SIZE,  32'sd0}},
    '{CMD_POP_FRONT,  4'd3,  32'sd9,         1'b1, 1'b0, '{KIND_SIZE,  32'sd0}},
    '{CMD_SIZE,       4'd3,  32'sd0,         1'b1, 1'b1, '{KIND_SIZE,  32'sd0}},
    // unused command code is dropped
    '{CMD_UNUSED,     4'd0,  32'sh7fffffff,  1'b1, 1'b0, '{KIND_SIZE,  32'sd0}},
    // extremes of the word at both ends
    '{CMD_PUSH_BACK,  4'd0,  32'sh7fffffff,  1'b1, 1'b0, '{KIND_SIZE,  32'sd0}},
    '{CMD_PUSH_BACK,  4'd0,  32'sh80000000,  1'b1, 1'b0, '{KIND_SIZE,  32'sd0}},
    '{CMD_FRONT,      4'd0,  32'sd0,         1'b1, 1'b1, '{KIND_FRONT, 32'sh7fffffff}},
    '{CMD_BACK,       4'd0,  32'sd0,         1'b1, 1'b1, '{KIND_BACK,  32'sh80000000}},
    '{CMD_SIZE,       4'd0,  32'sd0,         1'b1, 1'b1, '{KIND_SIZE,  32'sd2}},
    // a front push on a fresh queue wraps the head below slot zero
    '{CMD_PUSH_FRONT, 4'd15, -32'sd1,        1'b1, 1'b0, '{KIND_SIZE,  32'sd0}},
    '{CMD_PUSH_FRONT, 4'd15, 32'sd0,         1'b1, 1'b0, '{KIND_SIZE,  32'sd0}},
    '{CMD_FRONT,      4'd15, 32'sd0,         1'b1, 1'b1, '{KIND_FRONT, 32'sd0}},
    '{CMD_BACK,       4'd15, 32'sd0,         1'b1, 1'b1, '{KIND_BACK,  -32'sd1}},
    '{CMD_POP_FRONT,  4'd15, 32'sd0,         1'b0, 1'b0, '{KIND_SIZE,  32'sd0}},
    '{CMD_FRONT,      4'd15, 32'sd0,         1'b0, 1'b0, '{KIND_SIZE,  32'sd0}},
    '{CMD_POP_BACK,   4'd0,  32'sd0,         1'b0, 1'b0, '{KIND_SIZE,  32'sd0}},
    '{CMD_BACK,       4'd0,  32'sd0,         1'b0, 1'b0, '{KIND_SIZE,  32'sd0}},
    '{CMD_UNUSED,     4'd15, -32'sd1,        1'b1, 1'b0, '{KIND_SIZE,  32'sd0}},
    '{CMD_POP_BACK,   4'd15, 32'sd0,         1'b0, 1'b0, '{KIND_SIZE,  32'sd0}},
    // one pop too many
    '{CMD_POP_BACK,   4'd15, 32'sd0,         1'b0, 1'b0, '{KIND_SIZE,  32'sd0}},
    '{CMD_SIZE,       4'd15, 32'sd0,         1'b0, 1'b0, '{KIND_SIZE,  32'sd0}}
  };

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ring slot of the word at offset off from the head of queue q
  function automatic logic [HEAD_W-1:0] slot_of(input int unsigned q, input int unsigned off);
    slot_of = HEAD_W'((32'(head_slot[q]) + off) % RING_DEPTH);
  endfunction

  // applies one command word to the shadow bank, returns 1 with the answer
  // when the command produces one
  function automatic bit deque_model_step(input logic [CMD_W-1:0] cmd,
                                          input logic [QIDX_W-1:0] qi,
                                          input logic signed [WORD_W-1:0] word,
                                          output deque_answer_t ans);
    int unsigned q;
    int unsigned cnt;
    bit          answers;
    q       = 32'(qi);
    answers = 1'b0;
    ans     = '{KIND_SIZE, 32'sd0};
    if (q < NQ) begin
      cnt = 32'(word_count[q]);
      case (cmd)
        CMD_PUSH_BACK: begin
          // full queue drops the word
          if (cnt < RING_DEPTH) begin
            ring_words[q][slot_of(q, cnt)] = word;
            word_count[q] = (HEAD_W + 1)'(cnt + 1);
          end
        end
        CMD_POP_BACK: begin
          if (cnt != 0) word_count[q] = (HEAD_W + 1)'(cnt - 1);
        end
        CMD_PUSH_FRONT: begin
          if (cnt < RING_DEPTH) begin
            head_slot[q] = HEAD_W'((32'(head_slot[q]) + RING_DEPTH - 1) % RING_DEPTH);
            ring_words[q][slot_of(q, 0)] = word;
            word_count[q] = (HEAD_W + 1)'(cnt + 1);
          end
        end
        CMD_POP_FRONT: begin
          if (cnt != 0) begin
            head_slot[q] = HEAD_W'((32'(head_slot[q]) + 1) % RING_DEPTH);
            word_count[q] = (HEAD_W + 1)'(cnt - 1);
          end
        end
        CMD_SIZE: begin
          answers = 1'b1;
          ans     = '{KIND_SIZE, WORD_W'(cnt)};
        end
        CMD_FRONT: begin
          if (cnt != 0) begin
            answers = 1'b1;
            ans     = '{KIND_FRONT, ring_words[q][slot_of(q, 0)]};
          end
        end
        CMD_BACK: begin
          if (cnt != 0) begin
            answers = 1'b1;
            ans     = '{KIND_BACK, ring_words[q][slot_of(q, cnt - 1)]};
          end
        end
        default: ;
      endcase
    end
    deque_model_step = answers;
  endfunction

  function automatic logic signed [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0:       rand_word = 32'sh7fffffff;
      1:       rand_word = 32'sh80000000;
      2:       rand_word = 32'sd0;
      3:       rand_word = -32'sd1;
      default: rand_word = $urandom;
    endcase
  endfunction

  function automatic stim_row_t plain_row(input logic [CMD_W-1:0] cmd,
                                          input int unsigned q,
                                          input logic signed [WORD_W-1:0] word);
    plain_row = '{cmd, QIDX_W'(q), word, 1'b0, 1'b0, '{KIND_SIZE, 32'sd0}};
  endfunction

  // sends one command word, called and returning at a falling edge; the
  // sender runs in bursts with random gaps between them
  task automatic issue(input stim_row_t row);
    deque_answer_t predicted;
    bit            has_answer;
    int unsigned   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    req_bus.valid       <= 1'b1;
    req_bus.command     <= row.cmd;
    req_bus.queue_index <= row.qi;
    req_bus.value       <= row.word;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    // word taken at this edge: shadow bank always advances, typed rows
    // override the predicted answer
    has_answer = deque_model_step(row.cmd, row.qi, row.word, predicted);
    if (row.typed) begin
      has_answer = row.answers;
      predicted  = row.ans;
    end
    if (has_answer) pending_answers = {pending_answers, predicted};
    if (row.cmd != CMD_UNUSED) words_issued++;
    @(negedge clk);
  endtask

  // answer receiver: stalls on patterns of its own, with stretches of
  // steady ready and stretches of long stalls
  initial begin
    bit [7:0]    stall_mask;
    int unsigned stretch;
    int unsigned mode;
    rsp_bus.ready = 1'b0;
    forever begin
      mode       = $urandom_range(0, 3);
      stretch    = $urandom_range(16, 64);
      stall_mask = 8'($urandom) | 8'h01;
      for (int i = 0; i < stretch; i++) begin
        @(negedge clk);
        case (mode)
          0:       rsp_bus.ready <= 1'b1;
          1:       rsp_bus.ready <= stall_mask[i % 8];
          2:       rsp_bus.ready <= (i % 12) >= 9;
          default: rsp_bus.ready <= $urandom_range(0, 3) != 0;
        endcase
      end
    end
  end

  // answer checker: every taken answer against the oldest prediction
  always @(posedge clk) begin
    deque_answer_t exp_ans;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected answer: result_kind %0d result_value %0d",
               rsp_bus.result_kind, rsp_bus.result_value);
        errors_seen++;
      end else begin
        exp_ans = pending_answers[0];
        pending_answers.delete(0);
        if (rsp_bus.result_kind !== exp_ans.kind) begin
          $error("result_kind: expected %0d, got %0d", exp_ans.kind, rsp_bus.result_kind);
          errors_seen++;
        end
        if (rsp_bus.result_value !== exp_ans.value) begin
          $error("result_value: expected %0d, got %0d", exp_ans.value, rsp_bus.result_value);
          errors_seen++;
        end
      end
    end
  end

  // main stimulus
  initial begin
    int unsigned base_count;
    int unsigned fill_at;
    int unsigned seg;
    int unsigned qa;
    int unsigned qb;
    int unsigned q;
    int unsigned pick;
    bit          fill_done;
    logic [CMD_W-1:0] cmd;

    rst                 = 1'b1;
    req_bus.valid       = 1'b0;
    req_bus.command     = CMD_SIZE;
    req_bus.queue_index = '0;
    req_bus.value       = '0;
    words_issued        = 0;
    burst_left          = 0;
    errors_seen         = 0;
    fill_done           = 1'b0;
    for (int i = 0; i < NQ; i++) begin
      head_slot[i]  = '0;
      word_count[i] = '0;
    end

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) issue(directed_rows[i]);

    // random traffic; one fill past full and drain past empty somewhere
    // along the way
    base_count = words_issued;
    fill_at    = $urandom_range(50, 250);
    while (words_issued - base_count < RANDOM_ITEMS) begin
      if (!fill_done && words_issued - base_count >= fill_at) begin
        q = $urandom_range(0, NQ - 1);
        repeat (RING_DEPTH + 4) begin
          issue(plain_row($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, q,
                          rand_word()));
          if ($urandom_range(0, 7) == 0)
            issue(plain_row(read_cmds[$urandom_range(0, 2)], q, rand_word()));
        end
        issue(plain_row(CMD_SIZE, q, rand_word()));
        issue(plain_row(CMD_FRONT, q, rand_word()));
        issue(plain_row(CMD_BACK, q, rand_word()));
        repeat (RING_DEPTH + 4) begin
          issue(plain_row($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT, q,
                          rand_word()));
          if ($urandom_range(0, 7) == 0)
            issue(plain_row(read_cmds[$urandom_range(0, 2)], q, rand_word()));
        end
        fill_done = 1'b1;
      end
      seg = $urandom_range(0, 9);
      if (seg < 7) begin
        // mixed traffic focused on two queues, pushes outweigh pops
        qa = $urandom_range(0, NQ - 1);
        qb = $urandom_range(0, NQ - 1);
        repeat ($urandom_range(20, 40)) begin
          pick = $urandom_range(0, 99);
          if (pick < 22)      cmd = CMD_PUSH_BACK;
          else if (pick < 40) cmd = CMD_PUSH_FRONT;
          else if (pick < 52) cmd = CMD_POP_BACK;
          else if (pick < 62) cmd = CMD_POP_FRONT;
          else if (pick < 74) cmd = CMD_SIZE;
          else if (pick < 87) cmd = CMD_FRONT;
          else if (pick < 98) cmd = CMD_BACK;
          else                cmd = CMD_UNUSED;
          case ($urandom_range(0, 3))
            0, 1:    q = qa;
            2:       q = qb;
            default: q = $urandom_range(0, NQ - 1);
          endcase
          issue(plain_row(cmd, q, rand_word()));
        end
      end else if (seg == 7) begin
        // noise: any code, any queue, any word
        repeat ($urandom_range(4, 10))
          issue(plain_row(CMD_W'($urandom_range(0, 7)), $urandom_range(0, NQ - 1),
                          $urandom));
      end else begin
        // empty one queue, then poke it while empty
        q = $urandom_range(0, NQ - 1);
        while (word_count[q] != 0) begin
          issue(plain_row($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT, q,
                          rand_word()));
          if ($urandom_range(0, 2) == 0)
            issue(plain_row(read_cmds[$urandom_range(0, 2)], q, rand_word()));
        end
        issue(plain_row($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT, q,
                        rand_word()));
        issue(plain_row(CMD_FRONT, q, rand_word()));
        issue(plain_row(CMD_BACK, q, rand_word()));
        issue(plain_row(CMD_SIZE, q, rand_word()));
      end
    end

    req_bus.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors_seen == 0) begin
      $display("multi_deque_bank_tb: done, clean");
    end else begin
      $display("multi_deque_bank_tb: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("multi_deque_bank_tb: done, errors");
    $finish;
  end

endmodule
